@@ src/hamiltonian_cycle_search_defines.svh @@
// ----------------------------------------------------------------------------
// hamiltonian cycle search assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef HAMILTONIAN_CYCLE_SEARCH_DEFINES_SVH
`define HAMILTONIAN_CYCLE_SEARCH_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define HCS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hcs_pkg.sv @@
// ----------------------------------------------------------------------------
// hcs_pkg
// types, codes and helper functions of the hamiltonian cycle search block
// ----------------------------------------------------------------------------
`default_nettype none

package hcs_pkg;

    // operation codes of an input beat
    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_NODE_COUNT = 1'b0,
        CFG_START_NODE = 1'b1
    } t_cfg_idx;

    localparam logic [4:0] NODE_COUNT_RESET = 5'd5;
    localparam logic [3:0] START_NODE_RESET = 4'd0;

    typedef struct packed {
        logic        operation;
        logic [3:0]  row_index;
        logic [15:0] row_bits;
    } t_in_beat;

    typedef struct packed {
        logic       found;
        logic [3:0] node;
        logic       last;
    } t_out_beat;

    // one stack entry: node on the path and the next neighbor to try
    typedef struct packed {
        logic [3:0] node;
        logic [4:0] next_cand;
    } t_frame;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } t_pick;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPAND,
        S_POP,
        S_RD,
        S_WR
    } t_state;

    // lowest set bit of a candidate vector
    function automatic t_pick lowest_set(input logic [15:0] v);
        t_pick p;
        p.hit = 1'b0;
        p.idx = 4'd0;
        for (int i = 15; i >= 0; i--) begin
            if (v[i]) begin
                p.hit = 1'b1;
                p.idx = 4'(i);
            end
        end
        return p;
    endfunction

    // bits strictly below n set, n in 0..16
    function automatic logic [15:0] below_mask(input logic [4:0] n);
        logic [16:0] m;
        m = (17'd1 << n) - 17'd1;
        return m[15:0];
    endfunction

endpackage

`default_nettype wire

@@ src/hamiltonian_cycle_search.sv @@
// ----------------------------------------------------------------------------
// hamiltonian_cycle_search
// depth-first backtracking search for a hamiltonian cycle over a loaded graph
// ----------------------------------------------------------------------------
// A load beat (operation 0) writes one adjacency row, so loads stream at one
// beat per cycle while no search is running. A search beat (operation 1) holds
// off the input until its last result beat is loaded into the output register.
// The search keeps the top of the path in registers and the rest of the path
// in a stack memory; each push does one adjacency memory read, each pop a
// stack memory read, then an adjacency memory read, and each result beat a
// stack read, then a load of the output register. After the search beat is
// taken the input stays stalled through the pushes, pops, result beats and a
// final expand step that closes the cycle or exhausts the root, or only
// through the single result beat when the start node lies outside the graph,
// plus any output stall. A found cycle gives eff_count beats, start node
// first, last one marked; else one beat, found and node zero, marked last.
// No clearing pass after reset: adjacency rows must be loaded before a search
// reads them.
`default_nettype none

module hamiltonian_cycle_search #(
    parameter int MAX_NODES = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire hcs_pkg::t_in_beat i_in_data,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output hcs_pkg::t_out_beat     o_out_data,
    // configuration writes
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_index,
    input  wire logic [4:0]        i_cfg_wdata
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int FW = $bits(hcs_pkg::t_frame);
    // largest usable node count: limited by the store and by the 4-bit node field
    localparam logic [4:0] CAP = (MAX_NODES < 16) ? 5'(MAX_NODES) : 5'd16;

    // configuration registers
    logic [4:0] r_node_count;
    logic [3:0] r_start_node;

    // search registers: top of the path lives here, the rest in the stack
    hcs_pkg::t_state    r_state,   n_state;
    logic [4:0]         r_cnt,     n_cnt;
    logic [3:0]         r_cur,     n_cur;
    logic [4:0]         r_nc,      n_nc;
    logic [15:0]        r_mask,    n_mask;
    logic [4:0]         r_depth,   n_depth;
    logic               r_found,   n_found;
    logic [4:0]         r_k,       n_k;
    logic               r_out_valid, n_out_valid;
    hcs_pkg::t_out_beat r_out,     n_out;

    // memory ports
    logic                  adj_we,  adj_re;
    logic [AW-1:0]         adj_waddr, adj_raddr;
    logic [15:0]           adj_rdata;
    logic                  stk_we,  stk_re;
    logic [AW-1:0]         stk_waddr, stk_raddr;
    hcs_pkg::t_frame       stk_wdata, stk_rdata;

    logic       in_accept;
    logic       out_free;
    logic [4:0] eff_count;
    logic [15:0] cand;
    hcs_pkg::t_pick pick;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // node count of zero acts as one, large counts saturate
    always_comb begin
        if (r_node_count == 5'd0) begin
            eff_count = 5'd1;
        end else if (r_node_count > CAP) begin
            eff_count = CAP;
        end else begin
            eff_count = r_node_count;
        end
    end

    // neighbors of the top node that are in range, off the path, and not yet tried
    assign cand = adj_rdata & ~r_mask & hcs_pkg::below_mask(r_cnt)
                & ~hcs_pkg::below_mask(r_nc);
    assign pick = hcs_pkg::lowest_set(cand);

    // load path: rows beyond the store are dropped
    assign adj_we    = in_accept && (i_in_data.operation == hcs_pkg::OP_LOAD)
                    && (32'(i_in_data.row_index) < MAX_NODES);
    assign adj_waddr = AW'(i_in_data.row_index);

    hcs_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (16)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (i_in_data.row_bits),
        .i_re    (adj_re),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    hcs_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (FW)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= hcs_pkg::NODE_COUNT_RESET;
            r_start_node <= hcs_pkg::START_NODE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == hcs_pkg::CFG_NODE_COUNT) begin
                r_node_count <= i_cfg_wdata;
            end else begin
                r_start_node <= i_cfg_wdata[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hcs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_mask      <= '0;
            r_depth     <= '0;
            r_cnt       <= '0;
            r_k         <= '0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_mask      <= n_mask;
            r_depth     <= n_depth;
            r_cnt       <= n_cnt;
            r_k         <= n_k;
            r_found     <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_nc  <= n_nc;
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_cur       = r_cur;
        n_nc        = r_nc;
        n_mask      = r_mask;
        n_depth     = r_depth;
        n_found     = r_found;
        n_k         = r_k;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        adj_re    = 1'b0;
        adj_raddr = AW'(r_cur);
        stk_we    = 1'b0;
        stk_waddr = AW'(r_depth - 5'd1);
        stk_wdata = '{node: r_cur, next_cand: r_nc};
        stk_re    = 1'b0;
        stk_raddr = AW'(r_k);

        o_in_stall = (r_state != hcs_pkg::S_IDLE);

        case (r_state)
            hcs_pkg::S_IDLE: begin
                if (in_accept && (i_in_data.operation == hcs_pkg::OP_SEARCH)) begin
                    n_k = 5'd0;
                    if ({1'b0, r_start_node} < eff_count) begin
                        // root frame: start node, nothing tried yet
                        n_cnt     = eff_count;
                        n_cur     = r_start_node;
                        n_nc      = 5'd0;
                        n_mask    = 16'd1 << r_start_node;
                        n_depth   = 5'd1;
                        adj_re    = 1'b1;
                        adj_raddr = AW'(r_start_node);
                        n_state   = hcs_pkg::S_EXPAND;
                    end else begin
                        // start outside the graph: single not-found beat
                        n_cnt   = 5'd1;
                        n_found = 1'b0;
                        n_state = hcs_pkg::S_RD;
                    end
                end
            end

            hcs_pkg::S_EXPAND: begin
                if (r_depth == r_cnt && adj_rdata[r_start_node]) begin
                    // full path closes back to the start: save top and report
                    stk_we  = 1'b1;
                    n_found = 1'b1;
                    n_k     = 5'd0;
                    n_state = hcs_pkg::S_RD;
                end else if (r_depth != r_cnt && pick.hit) begin
                    // push: save resume point of the current top, descend
                    stk_we    = 1'b1;
                    stk_wdata = '{node: r_cur, next_cand: {1'b0, pick.idx} + 5'd1};
                    n_cur     = pick.idx;
                    n_nc      = 5'd0;
                    n_mask    = r_mask | (16'd1 << pick.idx);
                    n_depth   = r_depth + 5'd1;
                    adj_re    = 1'b1;
                    adj_raddr = AW'(pick.idx);
                end else if (r_depth == 5'd1) begin
                    // root exhausted
                    n_cnt   = 5'd1;
                    n_found = 1'b0;
                    n_k     = 5'd0;
                    n_state = hcs_pkg::S_RD;
                end else begin
                    // pop: fetch the frame below
                    n_mask    = r_mask & ~(16'd1 << r_cur);
                    n_depth   = r_depth - 5'd1;
                    stk_re    = 1'b1;
                    stk_raddr = AW'(r_depth - 5'd2);
                    n_state   = hcs_pkg::S_POP;
                end
            end

            hcs_pkg::S_POP: begin
                n_cur     = stk_rdata.node;
                n_nc      = stk_rdata.next_cand;
                adj_re    = 1'b1;
                adj_raddr = AW'(stk_rdata.node);
                n_state   = hcs_pkg::S_EXPAND;
            end

            hcs_pkg::S_RD: begin
                stk_re  = 1'b1;
                n_state = hcs_pkg::S_WR;
            end

            hcs_pkg::S_WR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.found = r_found;
                    n_out.node  = r_found ? stk_rdata.node : 4'd0;
                    n_out.last  = (r_k == r_cnt - 5'd1);
                    if (r_k == r_cnt - 5'd1) begin
                        n_state = hcs_pkg::S_IDLE;
                    end else begin
                        n_k     = r_k + 5'd1;
                        n_state = hcs_pkg::S_RD;
                    end
                end
            end

            default: begin
                n_state = hcs_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ src/hcs_ram.sv @@
// ----------------------------------------------------------------------------
// hcs_ram
// single-port-write, single-port-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module hcs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/hcs_checker.sv @@
// ----------------------------------------------------------------------------
// hcs_checker
// port-level checks of the hamiltonian cycle search block
// ----------------------------------------------------------------------------
`default_nettype none

`include "hamiltonian_cycle_search_defines.svh"

module hcs_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire hcs_pkg::t_in_beat  i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire hcs_pkg::t_out_beat o_out_data
);

    logic search_beat;
    logic load_beat;

    assign search_beat = i_in_valid && !o_in_stall
                      && (i_in_data.operation == hcs_pkg::OP_SEARCH);
    assign load_beat   = i_in_valid && !o_in_stall
                      && (i_in_data.operation == hcs_pkg::OP_LOAD);

    // a stalled result beat holds
    `HCS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "result beat changed under stall")

    // a not-found beat is alone and carries node zero
    `HCS_ASSERT_SAME(a_notfound_form, o_out_valid && !o_out_data.found, o_out_data.last && (o_out_data.node == 4'd0), "bad not-found beat")

    // input stays held while a search still has beats to deliver
    `HCS_ASSERT_SAME(a_busy_stall, o_out_valid && !o_out_data.last, o_in_stall, "input taken during a search")

    // a search beat always occupies the block
    `HCS_ASSERT_NEXT(a_search_busy, search_beat, o_in_stall, "search beat did not start a search")

    // a load taken while no result is pending never produces a result
    `HCS_ASSERT_NEXT(a_load_silent, load_beat && !o_out_valid, !o_out_valid, "load produced a result beat")

endmodule

bind hamiltonian_cycle_search hcs_checker u_hcs_checker (.*);

`default_nettype wire
